// File: hw/rtl/fceh_pkg.sv
package fceh_pkg;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    HIST_ALL = 2'd0,
    HIST_T0  = 2'd1,
    HIST_T1  = 2'd2,
    HIST_T23 = 2'd3
  } hist_e;

  typedef enum logic [1:0] {
    REG_RADIUS_SQ   = 2'd0,
    REG_PARTICLE_ID = 2'd1
  } cfg_reg_e;

  localparam logic [23:0] RADIUS_SQ_RESET   = 24'd640000;
  localparam logic [3:0]  PARTICLE_ID_RESET = 4'd1;

  typedef struct packed {
    op_e   op;
    logic  accepted;
    logic  fill;
    logic  hit;
    hist_e hist;
  } ctl_t;

endpackage

// File: hw/rtl/fceh_event_if.sv
interface fceh_event_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         particle_id;
  logic [2:0]         event_type;
  logic signed [16:0] energy;
  logic signed [11:0] west_x;
  logic signed [11:0] west_y;
  logic signed [11:0] east_x;
  logic signed [11:0] east_y;
  logic [1:0]         hist_select;
  logic [6:0]         read_bin;

  modport source (
    output valid, operation, particle_id, event_type, energy,
    output west_x, west_y, east_x, east_y, hist_select, read_bin,
    input  ready
  );
  modport sink (
    input  valid, operation, particle_id, event_type, energy,
    input  west_x, west_y, east_x, east_y, hist_select, read_bin,
    output ready
  );
endinterface

// File: hw/rtl/fceh_result_if.sv
interface fceh_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  filled_bin;
  logic [31:0] count_value;

  modport source (output valid, accepted, filled_bin, count_value, input ready);
  modport sink (input valid, accepted, filled_bin, count_value, output ready);
endinterface

// File: hw/rtl/fceh_cfg_if.sv
interface fceh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/fceh_front.sv
module fceh_front
  import fceh_pkg::*;
#(
  parameter int NUM_BINS        = 120,
  parameter int BIN_WIDTH_UNITS = 160,
  localparam int BINW           = $clog2(NUM_BINS + 2)
) (
  input  logic            clk,
  input  logic            rst,
  fceh_event_if.sink      evt,
  fceh_cfg_if.sink        cfg,
  input  logic            clearing,
  input  logic            push_ready,
  output logic            push_valid,
  output ctl_t            push_ctl,
  output logic [BINW-1:0] push_bin
);

  localparam int EMAX  = NUM_BINS * BIN_WIDTH_UNITS;
  localparam int EW    = $clog2(EMAX + 1);
  localparam int BW    = $clog2(BIN_WIDTH_UNITS + 1);
  localparam int SHIFT = EW + BW;
  localparam int MW    = EW + 2;
  localparam int PW    = EW + MW;
  localparam logic [63:0] MULT =
    ((64'd1 << SHIFT) + 64'(BIN_WIDTH_UNITS) - 64'd1) / 64'(BIN_WIDTH_UNITS);

  logic [23:0] radius_sq;
  logic [3:0]  particle_sel;

  logic signed [23:0] wxx, wyy, exx, eyy;
  logic [24:0]        west_r2, east_r2;
  logic               keep;
  logic               e_neg, e_over;
  logic [15:0]        e_mag;
  logic [PW-1:0]      prod;
  logic [BINW-1:0]    ebin;
  logic               fill;
  logic               rd_in_range;
  hist_e              type_hist;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq    <= RADIUS_SQ_RESET;
      particle_sel <= PARTICLE_ID_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RADIUS_SQ:   radius_sq    <= cfg.data;
        REG_PARTICLE_ID: particle_sel <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  assign wxx = 24'(evt.west_x) * 24'(evt.west_x);
  assign wyy = 24'(evt.west_y) * 24'(evt.west_y);
  assign exx = 24'(evt.east_x) * 24'(evt.east_x);
  assign eyy = 24'(evt.east_y) * 24'(evt.east_y);
  assign west_r2 = 25'(unsigned'(wxx)) + 25'(unsigned'(wyy));
  assign east_r2 = 25'(unsigned'(exx)) + 25'(unsigned'(eyy));

  assign keep = (evt.particle_id == particle_sel)
             && (west_r2 <= 25'(radius_sq))
             && (east_r2 <= 25'(radius_sq));

  assign e_neg  = evt.energy[16];
  assign e_mag  = evt.energy[15:0];
  assign e_over = !e_neg && (32'(e_mag) >= 32'(EMAX));
  assign prod   = PW'(EW'(e_mag)) * PW'(MW'(MULT));

  always_comb begin
    if (e_neg) begin
      ebin = '0;
    end else if (e_over) begin
      ebin = BINW'(NUM_BINS + 1);
    end else begin
      ebin = BINW'(prod >> SHIFT) + BINW'(1);
    end
  end

  always_comb begin
    case (evt.event_type[1:0])
      2'd0:    type_hist = HIST_T0;
      2'd1:    type_hist = HIST_T1;
      default: type_hist = HIST_T23;
    endcase
  end

  assign rd_in_range = int'(evt.read_bin) < NUM_BINS + 2;
  assign fill        = keep && !evt.event_type[2];

  always_comb begin
    push_ctl    = '0;
    push_bin    = '0;
    push_ctl.op = op_e'(evt.operation);
    if (op_e'(evt.operation) == OP_READ) begin
      push_ctl.hist = hist_e'(evt.hist_select);
      push_ctl.hit  = rd_in_range;
      push_bin      = BINW'(evt.read_bin);
    end else begin
      push_ctl.accepted = keep;
      push_ctl.fill     = fill;
      push_ctl.hit      = 1'b1;
      push_ctl.hist     = type_hist;
      push_bin          = fill ? ebin : '0;
    end
  end

  assign evt.ready  = push_ready && !clearing;
  assign push_valid = evt.valid && !clearing;

endmodule

// File: hw/rtl/fceh_fifo.sv
module fceh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;
  logic             push, pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/fceh_back.sv
module fceh_back
  import fceh_pkg::*;
#(
  parameter int NUM_BINS    = 120,
  parameter int COUNT_WIDTH = 32,
  localparam int AW         = $clog2(NUM_BINS + 2)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ctl_t          q_ctl,
  input  logic [AW-1:0] q_bin,
  output logic          q_pop,
  output logic          clearing,
  fceh_result_if.source res
);

  localparam int NB2 = NUM_BINS + 2;
  localparam int TD  = 3 * NB2;
  localparam int TW  = $clog2(TD);
  localparam int CW  = COUNT_WIDTH;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t          state;
  logic [TW-1:0]   clr_addr;
  ctl_t            cur_ctl;
  logic [AW-1:0]   cur_bin;
  logic [TW-1:0]   cur_taddr;

  logic [CW-1:0]   mem_all [NB2];
  logic [CW-1:0]   mem_typ [TD];
  logic [CW-1:0]   all_q, typ_q;
  logic [CW-1:0]   all_inc, typ_inc, cnt_sel;

  logic [TW-1:0]   typ_base, ra_typ;
  logic [AW-1:0]   ra_all;
  logic            out_free;
  logic            we_all, we_typ, do_fill;
  logic [AW-1:0]   wa_all;
  logic [TW-1:0]   wa_typ;
  logic [CW-1:0]   wd_all, wd_typ;

  logic            res_valid;
  logic            res_accepted;
  logic [6:0]      res_bin;
  logic [31:0]     res_count;

  always_comb begin
    case (q_ctl.hist)
      HIST_T1:  typ_base = TW'(NB2);
      HIST_T23: typ_base = TW'(2 * NB2);
      default:  typ_base = '0;
    endcase
  end

  assign ra_all   = q_ctl.hit ? q_bin : '0;
  assign ra_typ   = typ_base + TW'(ra_all);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign clearing = state == ST_CLEAR;
  assign out_free = !res_valid || res.ready;

  assign all_inc = (all_q == '1) ? all_q : all_q + CW'(1);
  assign typ_inc = (typ_q == '1) ? typ_q : typ_q + CW'(1);
  assign cnt_sel = (cur_ctl.hist == HIST_ALL) ? all_q : typ_q;
  assign do_fill = (state == ST_UPDATE) && out_free && cur_ctl.fill;

  always_comb begin
    if (state == ST_CLEAR) begin
      we_all = clr_addr < TW'(NB2);
      we_typ = 1'b1;
      wa_all = AW'(clr_addr);
      wa_typ = clr_addr;
      wd_all = '0;
      wd_typ = '0;
    end else begin
      we_all = do_fill;
      we_typ = do_fill;
      wa_all = cur_bin;
      wa_typ = cur_taddr;
      wd_all = all_inc;
      wd_typ = typ_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (we_all) begin
      mem_all[wa_all] <= wd_all;
    end
    if (q_pop) begin
      all_q <= mem_all[ra_all];
    end
  end

  always_ff @(posedge clk) begin
    if (we_typ) begin
      mem_typ[wa_typ] <= wd_typ;
    end
    if (q_pop) begin
      typ_q <= mem_typ[ra_typ];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && !((state == ST_UPDATE) && out_free)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + TW'(1);
          if (clr_addr == TW'(TD - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur_ctl   <= q_ctl;
            cur_bin   <= q_bin;
            cur_taddr <= ra_typ;
            state     <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            res_accepted <= cur_ctl.accepted;
            res_bin      <= (cur_ctl.op == OP_READ) ? 7'd0 : 7'(cur_bin);
            res_count    <= (cur_ctl.op == OP_READ && cur_ctl.hit)
                            ? 32'(64'(cnt_sel)) : 32'd0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.accepted    = res_accepted;
  assign res.filled_bin  = res_bin;
  assign res.count_value = res_count;

`ifndef ASSERT_OFF
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_fill_only_events: assert property (@(posedge clk) disable iff (rst)
    (we_typ && state != ST_CLEAR) |-> (cur_ctl.op == OP_EVENT && cur_ctl.accepted))
    else $error("counter written for an item that fills nothing");

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_UPDATE)
    else $error("result raised outside update");

  a_update_follows_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_UPDATE)
    else $error("pop not followed by update");
`endif

endmodule

// File: hw/rtl/fiducial_cut_energy_histogrammer.sv
// An input beat waits in the FIFO; the back end pops it in its idle state and reads the
// counter memories, whose read data is registered before the saturating increment. In
// its update state, once the result side is free, it completes the read-modify-write for
// a fill and registers the result beat; it holds one item until that update is done.
// Reset: synchronous, active high; configuration returns to its defaults, then a
// clearing pass zeroes every counter, with input ready held low meanwhile.
module fiducial_cut_energy_histogrammer
  import fceh_pkg::*;
#(
  parameter int NUM_BINS        = 120,
  parameter int BIN_WIDTH_UNITS = 160,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic          clk,
  input  logic          rst,
  fceh_cfg_if.sink      cfg,
  fceh_event_if.sink    evt,
  fceh_result_if.source res
);

  localparam int BINW = $clog2(NUM_BINS + 2);
  localparam int QW   = $bits(ctl_t) + BINW;

  logic            push_valid, push_ready;
  ctl_t            push_ctl;
  logic [BINW-1:0] push_bin;
  logic            pop_valid, pop;
  logic [QW-1:0]   pop_data;
  ctl_t            q_ctl;
  logic [BINW-1:0] q_bin;
  logic            clearing;

  fceh_front #(
    .NUM_BINS        (NUM_BINS),
    .BIN_WIDTH_UNITS (BIN_WIDTH_UNITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .cfg        (cfg),
    .clearing   (clearing),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_ctl   (push_ctl),
    .push_bin   (push_bin)
  );

  fceh_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_bin}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop),
    .pop_data   (pop_data)
  );

  assign {q_ctl, q_bin} = pop_data;

  fceh_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_ctl    (q_ctl),
    .q_bin    (q_bin),
    .q_pop    (pop),
    .clearing (clearing),
    .res      (res)
  );

endmodule
